### design/lif_pkg.sv
// Shared types and constants for the leaky integrate-and-fire neuron core.
package lif_pkg;

  localparam int MEMB_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int THR_W = 31;
  localparam int LEAK_W = 16;
  localparam int REFR_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  // Q1.15 unity.
  localparam logic [LEAK_W-1:0] Q_ONE = 16'h8000;

  localparam logic OP_SYNAPSE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 31'd1000;
  localparam logic [LEAK_W-1:0] LEAK_RST = 16'd29491;
  localparam logic [REFR_W-1:0] REFRACTORY_RST = 4'd3;

  typedef struct packed {
    logic                opcode;
    logic [WEIGHT_W-1:0] weight;
    logic                inhibitory;
  } in_item_t;

  typedef struct packed {
    logic signed [MEMB_W-1:0] membrane;
    logic                     spike;
    logic                     dropped;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;       // count a tick and run down the refractory counter
    logic start;      // latch a synaptic request and set up the power loop
    logic pow_step;   // one square-and-multiply step
    logic scale;      // membrane magnitude times the leak power
    logic decay;      // write back the signed, truncated product
    logic fin_syn;    // add the weight, fire check, load the result
    logic fin_pass;   // load the unchanged membrane as the result
    logic pass_drop;  // the passed-through result flags a dropped input
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;     // no exponent bits left
    logic blocked;    // refractory period in progress
  } dp_status_t;

endpackage

### design/lif_ctrl.sv
// Controller state machine for the neuron core: sequencing and output handshake.
module lif_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  output logic                out_valid,
  input  logic                out_stall,
  input  lif_pkg::dp_status_t status,
  output lif_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POW   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] KIND_SYN  = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       load_out;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    cmd = '0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == lif_pkg::OP_TICK) begin
            cmd.tick = 1'b1;
            kind_nxt = KIND_TICK;
            state_nxt = S_FIN;
          end else if (status.blocked) begin
            kind_nxt = KIND_DROP;
            state_nxt = S_FIN;
          end else begin
            cmd.start = 1'b1;
            kind_nxt = KIND_SYN;
            state_nxt = S_POW;
          end
        end
      end
      S_POW: begin
        if (status.n_zero) begin
          state_nxt = S_SCALE;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DECAY;
      end
      S_DECAY: begin
        cmd.decay = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_nxt = S_IDLE;
          case (kind_r)
            KIND_SYN: cmd.fin_syn = 1'b1;
            KIND_DROP: begin
              cmd.fin_pass = 1'b1;
              cmd.pass_drop = 1'b1;
            end
            default: cmd.fin_pass = 1'b1;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= KIND_SYN;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/lif_dp.sv
// Datapath for the neuron core: config registers, neuron state, leak power and update.
module lif_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lif_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lif_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lif_pkg::in_item_t                 in_data,
  input  lif_pkg::dp_cmd_t                  cmd,
  output lif_pkg::dp_status_t               status,
  output lif_pkg::out_item_t                out_data
);

  logic [lif_pkg::THR_W-1:0]    thr_r;
  logic [lif_pkg::LEAK_W-1:0]   leak_r;
  logic [lif_pkg::REFR_W-1:0]   refr_r;

  logic signed [lif_pkg::MEMB_W-1:0] memb_r, memb_nxt;
  logic [31:0]                  tick_r;
  logic [31:0]                  last_r;
  logic [lif_pkg::REFR_W-1:0]   refl_r, refl_nxt;

  logic [lif_pkg::WEIGHT_W-1:0] weight_r;
  logic                         inhib_r;
  logic [31:0]                  n_r;
  logic [lif_pkg::LEAK_W-1:0]   acc_r, base_r;
  logic [47:0]                  prod_r;
  logic                         neg_r;
  lif_pkg::out_item_t           out_r, out_nxt;

  logic [lif_pkg::LEAK_W-1:0]   base_init;
  logic [31:0]                  acc_prod, base_prod;
  logic [31:0]                  mag;
  logic [31:0]                  decayed;
  logic [32:0]                  sum;
  logic [32:0]                  w_ext;
  logic [31:0]                  sat;
  logic                         fire;

  assign status.n_zero = (n_r == 32'd0);
  assign status.blocked = (refl_r != '0);
  assign out_data = out_r;

  // A factor above unity behaves as unity.
  assign base_init = (leak_r > lif_pkg::Q_ONE) ? lif_pkg::Q_ONE : leak_r;

  // Both operands stay at or below unity, so each Q1.15 product fits in 16 bits.
  assign acc_prod = 32'(acc_r) * 32'(base_r);
  assign base_prod = 32'(base_r) * 32'(base_r);

  assign mag = memb_r[31] ? (32'd0 - $unsigned(memb_r)) : $unsigned(memb_r);
  assign decayed = neg_r ? (32'd0 - prod_r[46:15]) : prod_r[46:15];

  assign w_ext = {17'd0, weight_r};
  assign sum = inhib_r ? ({memb_r[31], memb_r} - w_ext) : ({memb_r[31], memb_r} + w_ext);

  always_comb begin
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = sum[31:0];
    end
  end

  assign fire = $signed(sat) > $signed({1'b0, thr_r});

  always_comb begin
    memb_nxt = memb_r;
    refl_nxt = refl_r;
    out_nxt = out_r;
    if (cmd.tick && (refl_r != '0)) begin
      refl_nxt = refl_r - lif_pkg::REFR_W'(1);
    end
    if (cmd.decay) begin
      memb_nxt = decayed;
    end
    if (cmd.fin_syn) begin
      out_nxt.spike = fire;
      out_nxt.dropped = 1'b0;
      if (fire) begin
        memb_nxt = '0;
        out_nxt.membrane = '0;
        refl_nxt = (refr_r == '0) ? lif_pkg::REFR_W'(1) : refr_r;
      end else begin
        memb_nxt = sat;
        out_nxt.membrane = sat;
      end
    end
    if (cmd.fin_pass) begin
      out_nxt.membrane = memb_r;
      out_nxt.spike = 1'b0;
      out_nxt.dropped = cmd.pass_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= lif_pkg::THRESHOLD_RST;
      leak_r <= lif_pkg::LEAK_RST;
      refr_r <= lif_pkg::REFRACTORY_RST;
      memb_r <= '0;
      tick_r <= '0;
      last_r <= '0;
      refl_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lif_pkg::CFG_THRESHOLD: thr_r <= cfg_data;
          lif_pkg::CFG_LEAK: leak_r <= cfg_data[lif_pkg::LEAK_W-1:0];
          lif_pkg::CFG_REFRACTORY: refr_r <= cfg_data[lif_pkg::REFR_W-1:0];
          default: ;
        endcase
      end
      memb_r <= memb_nxt;
      refl_r <= refl_nxt;
      if (cmd.tick) begin
        tick_r <= tick_r + 32'd1;
      end
      if (cmd.fin_syn) begin
        last_r <= tick_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.start) begin
      weight_r <= in_data.weight;
      inhib_r <= in_data.inhibitory;
      n_r <= tick_r - last_r;
      acc_r <= lif_pkg::Q_ONE;
      base_r <= base_init;
    end
    if (cmd.pow_step) begin
      if (n_r[0]) begin
        acc_r <= acc_prod[30:15];
      end
      base_r <= base_prod[30:15];
      n_r <= {1'b0, n_r[31:1]};
    end
    if (cmd.scale) begin
      prod_r <= 48'(mag) * 48'(acc_r);
      neg_r <= memb_r[31];
    end
  end

endmodule

### design/leaky_integrate_fire_neuron_core.sv
// Top level of the leaky integrate-and-fire neuron core.
//
// Input requests (in_valid/in_stall, in_data) carry either a tick, which
// advances the time counter and runs down the refractory period, or a
// synaptic input with a weight and an inhibitory flag. Every request gives
// exactly one result request (out_valid/out_stall, out_data) with the new
// membrane value and the spike and dropped flags.
// Ticks and dropped inputs go straight from acceptance to the final step,
// which loads the result. For a synaptic input the leak power is built
// by one square-and-multiply step per cycle for each of the k bits of
// the tick count since the last synaptic input that was not dropped
// (k from 0 to 32); once the exponent has run out, a multiply, a
// write-back and an add-and-compare step follow; the last one loads
// the result.
// One request is in work at a time; the next is taken once the result sits
// in the output register, and the output register holds it while
// out_stall is high, with work on the next request waiting at its last step.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken and are meant for idle periods. Reset restores the default
// threshold, leak and refractory values and clears the neuron state.
module leaky_integrate_fire_neuron_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lif_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lif_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lif_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lif_pkg::CFG_DATA_W-1:0] cfg_data
);

  lif_pkg::dp_cmd_t    cmd;
  lif_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  lif_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lif_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
